FILE: rtl/rtpc_pkg.sv
// Shared types, widths and a helper function for the resistive touch point
// compute pipeline. No dependencies; every other rtl file imports this package.
package rtpc_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int PRESS_W     = 16;
   localparam int PLATE_W     = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam int PROD_W = 2 * SAMPLE_BITS;
   localparam int DEN_W  = 2 * SAMPLE_BITS;
   localparam int NUM_W  = PROD_W + PLATE_W;
   localparam int WIDE_W = (SAMPLE_BITS + 1 > PRESS_W + 1) ? SAMPLE_BITS + 1 : PRESS_W + 1;

   localparam int DIV_STAGES     = 8;
   localparam int BITS_PER_STAGE = PRESS_W / DIV_STAGES;

   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE   = {SAMPLE_BITS{1'b1}};
   localparam logic [PRESS_W-1:0]     PRESSURE_MAX = {PRESS_W{1'b1}};
   localparam logic [SAMPLE_BITS-1:0] NOISE_RESET  = SAMPLE_BITS'(16);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PLATE_RES    = 1'b0,
      REG_NOISE_WINDOW = 1'b1
   } csr_reg_type;

   // Fields that ride alongside the arithmetic through every stage.
   typedef struct packed {
      logic                   ok;
      logic                   use_div;
      logic [PRESS_W-1:0]     fixed_p;
      logic [SAMPLE_BITS-1:0] pos_x;
      logic [SAMPLE_BITS-1:0] pos_y;
   } side_type;

   // Output of the front stage.
   typedef struct packed {
      side_type               side;
      logic [SAMPLE_BITS-1:0] dz;
      logic [SAMPLE_BITS-1:0] z1;
      logic [PLATE_W-1:0]     plate;
   } front_type;

   // Working state of the restoring divider.
   typedef struct packed {
      logic [DEN_W-1:0]   rem;
      logic [PRESS_W-1:0] num_lo;
      logic [PRESS_W-1:0] quo;
      logic [DEN_W-1:0]   den;
   } div_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] pos_x;
      logic [SAMPLE_BITS-1:0] pos_y;
      logic [PRESS_W-1:0]     pressure;
      logic                   point_valid;
   } result_type;

   // One restoring step: bring in the next numerator bit, subtract if it fits.
   function automatic div_type div_step(div_type d);
      logic [DEN_W:0] trial;
      logic           qbit;
      div_type        r;
      trial = {d.rem, d.num_lo[PRESS_W-1]};
      qbit  = (trial >= {1'b0, d.den});
      if (qbit) begin
         trial = trial - {1'b0, d.den};
      end
      r        = d;
      r.rem    = trial[DEN_W-1:0];
      r.num_lo = {d.num_lo[PRESS_W-2:0], 1'b0};
      r.quo    = {d.quo[PRESS_W-2:0], qbit};
      return r;
   endfunction

endpackage

FILE: rtl/rtpc_front.sv
// Front stage: noise check and averaging of both axes, pressure case selection.
// Depends on rtpc_pkg.
module rtpc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [rtpc_pkg::SAMPLE_BITS-1:0] x_first,
   input  logic [rtpc_pkg::SAMPLE_BITS-1:0] x_second,
   input  logic [rtpc_pkg::SAMPLE_BITS-1:0] y_first,
   input  logic [rtpc_pkg::SAMPLE_BITS-1:0] y_second,
   input  logic [rtpc_pkg::SAMPLE_BITS-1:0] z_one,
   input  logic [rtpc_pkg::SAMPLE_BITS-1:0] z_two,
   input  logic [rtpc_pkg::PLATE_W-1:0]     plate_res,
   input  logic [rtpc_pkg::SAMPLE_BITS-1:0] noise_window,
   output logic                            out_valid,
   output rtpc_pkg::front_type             out_data
);
   import rtpc_pkg::*;

   logic                   valid_ff;
   front_type              data_ff, data_in;
   logic                   ok_x, ok_y;
   logic [SAMPLE_BITS-1:0] px, py;
   logic [WIDE_W-1:0]      simple_wide;
   logic [PRESS_W-1:0]     simple_p;

   // Returns the inverted position; the flag tells whether the pair was clean.
   function automatic logic [SAMPLE_BITS:0] axis_value(
      input logic [SAMPLE_BITS-1:0] a,
      input logic [SAMPLE_BITS-1:0] b,
      input logic [SAMPLE_BITS-1:0] win);
      logic [SAMPLE_BITS-1:0] diff;
      logic [SAMPLE_BITS:0]   sum;
      logic [SAMPLE_BITS-1:0] v;
      logic                   clean;
      diff  = (a > b) ? (a - b) : (b - a);
      sum   = {1'b0, a} + {1'b0, b};
      clean = (diff <= win);
      v     = clean ? sum[SAMPLE_BITS:1] : b;
      return {clean, FULL_SCALE - v};
   endfunction

   always_comb begin
      {ok_x, px}  = axis_value(x_first, x_second, noise_window);
      {ok_y, py}  = axis_value(y_first, y_second, noise_window);
      simple_wide = WIDE_W'(FULL_SCALE) + WIDE_W'(z_one) - WIDE_W'(z_two);
      simple_p    = (simple_wide > WIDE_W'(PRESSURE_MAX)) ? PRESSURE_MAX
                                                          : simple_wide[PRESS_W-1:0];

      data_in.side.ok      = ok_x & ok_y;
      data_in.side.pos_x   = px;
      data_in.side.pos_y   = py;
      data_in.side.use_div = 1'b0;
      data_in.dz           = z_two - z_one;
      data_in.z1           = z_one;
      data_in.plate        = plate_res;
      priority if (!(ok_x & ok_y)) begin
         data_in.side.fixed_p = '0;
      end else if (plate_res == '0) begin
         data_in.side.fixed_p = simple_p;
      end else if (z_one == '0) begin
         data_in.side.fixed_p = PRESSURE_MAX;
      end else if (z_two <= z_one) begin
         data_in.side.fixed_p = '0;
      end else begin
         data_in.side.fixed_p = '0;
         data_in.side.use_div = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/rtpc_div_step.sv
// One registered divider stage that resolves BITS_PER_STAGE quotient bits.
// Depends on rtpc_pkg.
module rtpc_div_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  rtpc_pkg::div_type   in_div,
   input  rtpc_pkg::side_type  in_side,
   output logic                out_valid,
   output rtpc_pkg::div_type   out_div,
   output rtpc_pkg::side_type  out_side
);
   import rtpc_pkg::*;

   logic     valid_ff;
   div_type  div_ff, div_in;
   side_type side_ff;

   always_comb begin
      div_in = in_div;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
         div_in = div_step(div_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff  <= div_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule

FILE: rtl/rtpc_skid.sv
// Output register with one skid entry; its fill state freezes the pipeline.
// Depends on rtpc_pkg.
module rtpc_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  rtpc_pkg::result_type in_data,
   output logic                 hold,
   output logic                 out_valid,
   output rtpc_pkg::result_type out_data,
   input  logic                 out_stall
);
   import rtpc_pkg::*;

   logic       out_valid_ff, skid_valid_ff;
   result_type out_ff, skid_ff;
   logic       arrive;

   // Nothing arrives while the skid entry is full, since the pipeline is frozen.
   assign arrive = in_valid & ~skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !out_stall) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= arrive;
         end
      end else if (arrive) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || !out_stall) begin
         out_ff <= skid_valid_ff ? skid_ff : in_data;
      end else if (arrive) begin
         skid_ff <= in_data;
      end
   end

   assign hold      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

FILE: rtl/resistive_touch_point_compute_top.sv
// Resistive touch point compute: top level with configuration registers,
// multiplier stages and the divider chain. Depends on rtpc_pkg, rtpc_front,
// rtpc_div_step and rtpc_skid.
//
// Usage. One reading set (two X samples, two Y samples, Z1 and Z2) is
// transferred on the req_ channel when req_valid is high and req_stall is
// low. Each reading set yields exactly one result transfer on the rsp_
// channel (position X and Y, pressure, point-valid flag), in order.
// Each result passes through a front stage, two multiplier stages, an
// overflow check, eight divider stages each resolving two quotient bits
// and the output register before it is offered on rsp_valid. Throughput
// is one reading set per cycle while req_stall is low, set by this fully
// pipelined datapath.
// When the receiver asserts rsp_stall, the result in the output register
// holds and one further result is caught in a skid entry; req_stall then
// rises and the whole pipeline freezes until the output drains, so no
// item is lost or repeated. req_stall comes from a register only.
// The csr_ channel writes plate_resistance (index 0) and noise_window
// (index 1); it is always ready and should only be used while idle.
// Synchronous reset empties the pipeline and restores plate_resistance to
// zero and noise_window to sixteen.
module resistive_touch_point_compute_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rtpc_pkg::SAMPLE_BITS-1:0] req_x_first,
   input  logic [rtpc_pkg::SAMPLE_BITS-1:0] req_x_second,
   input  logic [rtpc_pkg::SAMPLE_BITS-1:0] req_y_first,
   input  logic [rtpc_pkg::SAMPLE_BITS-1:0] req_y_second,
   input  logic [rtpc_pkg::SAMPLE_BITS-1:0] req_z_one,
   input  logic [rtpc_pkg::SAMPLE_BITS-1:0] req_z_two,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rtpc_pkg::SAMPLE_BITS-1:0] rsp_pos_x,
   output logic [rtpc_pkg::SAMPLE_BITS-1:0] rsp_pos_y,
   output logic [rtpc_pkg::PRESS_W-1:0]     rsp_touch_pressure,
   output logic                             rsp_point_valid,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rtpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rtpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rtpc_pkg::*;

   // Configuration registers.
   logic [PLATE_W-1:0]     plate_ff;
   logic [SAMPLE_BITS-1:0] noise_ff;

   // Global advance: the pipeline moves whenever the skid entry is empty.
   logic en;
   logic hold;

   // Front stage output.
   logic      s1_valid;
   front_type s1_data;

   // Stage 2: first product and denominator.
   logic              s2_valid_ff;
   side_type          s2_side_ff;
   logic [PROD_W-1:0] s2_prod_ff;
   logic [DEN_W-1:0]  s2_den_ff;
   logic [PLATE_W-1:0] s2_plate_ff;

   // Stage 3: full numerator.
   logic             s3_valid_ff;
   side_type         s3_side_ff;
   logic [NUM_W-1:0] s3_num_ff;
   logic [DEN_W-1:0] s3_den_ff;

   // Stage 4: overflow check and divider set-up.
   logic     s4_valid_ff;
   side_type s4_side_ff, s4_side_in;
   div_type  s4_div_ff, s4_div_in;
   logic     s4_over;

   // Divider chain, element 0 fed from stage 4.
   logic     dv_valid [0:DIV_STAGES];
   div_type  dv_div   [0:DIV_STAGES];
   side_type dv_side  [0:DIV_STAGES];

   result_type final_res;
   result_type out_res;

   assign en        = ~hold;
   assign req_stall = hold;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plate_ff <= '0;
         noise_ff <= NOISE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            REG_PLATE_RES:    plate_ff <= csr_wdata[PLATE_W-1:0];
            REG_NOISE_WINDOW: noise_ff <= csr_wdata[SAMPLE_BITS-1:0];
            default:          ;
         endcase
      end
   end

   rtpc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .x_first      (req_x_first),
      .x_second     (req_x_second),
      .y_first      (req_y_first),
      .y_second     (req_y_second),
      .z_one        (req_z_one),
      .z_two        (req_z_two),
      .plate_res    (plate_ff),
      .noise_window (noise_ff),
      .out_valid    (s1_valid),
      .out_data     (s1_data)
   );

   // Stage 2: (z2 - z1) * pos_x, and z1 * full scale as shift minus value.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_side_ff  <= s1_data.side;
         s2_prod_ff  <= PROD_W'(s1_data.dz) * PROD_W'(s1_data.side.pos_x);
         s2_den_ff   <= {s1_data.z1, {SAMPLE_BITS{1'b0}}} - DEN_W'(s1_data.z1);
         s2_plate_ff <= s1_data.plate;
      end
   end

   // Stage 3: multiply by the plate resistance.
   always_ff @(posedge clock) begin
      if (en) begin
         s3_side_ff <= s2_side_ff;
         s3_num_ff  <= NUM_W'(s2_prod_ff) * NUM_W'(s2_plate_ff);
         s3_den_ff  <= s2_den_ff;
      end
   end

   // Stage 4: the quotient exceeds the output range exactly when the upper
   // part of the numerator is not below the denominator. Otherwise that
   // upper part is a valid starting remainder for the restoring divider.
   always_comb begin
      s4_over          = (s3_num_ff[NUM_W-1:PRESS_W] >= s3_den_ff);
      s4_side_in       = s3_side_ff;
      s4_div_in.rem    = s3_num_ff[NUM_W-1:PRESS_W];
      s4_div_in.num_lo = s3_num_ff[PRESS_W-1:0];
      s4_div_in.quo    = '0;
      s4_div_in.den    = s3_den_ff;
      if (s3_side_ff.use_div && s4_over) begin
         s4_side_in.use_div = 1'b0;
         s4_side_in.fixed_p = PRESSURE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_side_ff <= s4_side_in;
         s4_div_ff  <= s4_div_in;
      end
   end

   assign dv_valid[0] = s4_valid_ff;
   assign dv_div[0]   = s4_div_ff;
   assign dv_side[0]  = s4_side_ff;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      rtpc_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_valid[g]),
         .in_div    (dv_div[g]),
         .in_side   (dv_side[g]),
         .out_valid (dv_valid[g+1]),
         .out_div   (dv_div[g+1]),
         .out_side  (dv_side[g+1])
      );
   end

   // Pick the quotient or the pressure fixed earlier in the pipeline.
   always_comb begin
      final_res.pos_x       = dv_side[DIV_STAGES].pos_x;
      final_res.pos_y       = dv_side[DIV_STAGES].pos_y;
      final_res.point_valid = dv_side[DIV_STAGES].ok;
      final_res.pressure    = dv_side[DIV_STAGES].use_div ? dv_div[DIV_STAGES].quo
                                                          : dv_side[DIV_STAGES].fixed_p;
   end

   rtpc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid[DIV_STAGES]),
      .in_data   (final_res),
      .hold      (hold),
      .out_valid (rsp_valid),
      .out_data  (out_res),
      .out_stall (rsp_stall)
   );

   assign rsp_pos_x          = out_res.pos_x;
   assign rsp_pos_y          = out_res.pos_y;
   assign rsp_touch_pressure = out_res.pressure;
   assign rsp_point_valid    = out_res.point_valid;

   // A full skid entry implies a result waiting in the output register.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid entry full while output register empty");

   // An invalid point must never report a pressure.
   a_invalid_zero_pressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_point_valid) |-> (rsp_touch_pressure == '0))
      else $error("invalid point carries nonzero pressure");

   // While the pipeline is frozen, the last divider stage must not move.
   a_frozen_pipeline: assert property (@(posedge clock) disable iff (reset)
      hold |=> ($stable(dv_valid[DIV_STAGES]) && $stable(dv_div[DIV_STAGES])))
      else $error("divider stage changed while the pipeline was frozen");

endmodule

FILE: test/tb.sv
// Self-checking testbench for resistive_touch_point_compute_top: reading sets
// go in, touch points are predicted and compared field by field on the way out.
// Depends on rtpc_pkg and the RTL of the touch point compute block only.
`timescale 1ns / 100ps

typedef struct packed {
   logic [rtpc_pkg::SAMPLE_BITS-1:0] x_first;
   logic [rtpc_pkg::SAMPLE_BITS-1:0] x_second;
   logic [rtpc_pkg::SAMPLE_BITS-1:0] y_first;
   logic [rtpc_pkg::SAMPLE_BITS-1:0] y_second;
   logic [rtpc_pkg::SAMPLE_BITS-1:0] z_one;
   logic [rtpc_pkg::SAMPLE_BITS-1:0] z_two;
} touch_reading_type;

typedef struct packed {
   logic [rtpc_pkg::SAMPLE_BITS-1:0] pos_x;
   logic [rtpc_pkg::SAMPLE_BITS-1:0] pos_y;
   logic [rtpc_pkg::PRESS_W-1:0]     pressure;
   logic                             point_valid;
} touch_point_type;

// Keeps its own copy of the two registers, works out the touch point that
// each accepted reading set must produce and checks the results in order.
class touch_scoreboard;
   logic [rtpc_pkg::PLATE_W-1:0]     plate_res;
   logic [rtpc_pkg::SAMPLE_BITS-1:0] noise_win;
   touch_point_type                  expected_points[$];
   int                               error_count;
   int                               points_checked;

   function new();
      plate_res      = '0;
      noise_win      = rtpc_pkg::NOISE_RESET;
      error_count    = 0;
      points_checked = 0;
   endfunction

   function void set_register(logic [rtpc_pkg::CSR_IDX_W-1:0] idx,
                              logic [rtpc_pkg::CSR_DATA_W-1:0] data);
      case (rtpc_pkg::csr_reg_type'(idx))
         rtpc_pkg::REG_PLATE_RES: begin
            plate_res = data[rtpc_pkg::PLATE_W-1:0];
         end
         rtpc_pkg::REG_NOISE_WINDOW: begin
            noise_win = data[rtpc_pkg::SAMPLE_BITS-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   // Noise check, averaging and inversion of one axis.
   function logic [rtpc_pkg::SAMPLE_BITS-1:0] axis_position(
         input  logic [rtpc_pkg::SAMPLE_BITS-1:0] a,
         input  logic [rtpc_pkg::SAMPLE_BITS-1:0] b,
         output bit                               clean);
      logic [rtpc_pkg::SAMPLE_BITS:0]   diff;
      logic [rtpc_pkg::SAMPLE_BITS:0]   sum;
      logic [rtpc_pkg::SAMPLE_BITS-1:0] mid;
      diff = (a > b) ? {1'b0, a} - {1'b0, b} : {1'b0, b} - {1'b0, a};
      sum  = {1'b0, a} + {1'b0, b};
      if (diff > {1'b0, noise_win}) begin
         clean = 1'b0;
         mid   = b;
      end else begin
         clean = 1'b1;
         mid   = sum[rtpc_pkg::SAMPLE_BITS:1];
      end
      return rtpc_pkg::FULL_SCALE - mid;
   endfunction

   function touch_point_type predict_point(touch_reading_type r);
      touch_point_type p;
      bit             x_ok;
      bit             y_ok;
      longint unsigned press;
      longint unsigned dz;
      longint unsigned full;
      full    = longint'(rtpc_pkg::FULL_SCALE);
      p.pos_x = axis_position(r.x_first, r.x_second, x_ok);
      p.pos_y = axis_position(r.y_first, r.y_second, y_ok);
      if (plate_res != 0) begin
         if (r.z_one == 0) begin
            press = 65535;
         end else if (r.z_two <= r.z_one) begin
            press = 0;
         end else begin
            dz    = longint'(r.z_two) - longint'(r.z_one);
            press = (dz * longint'(p.pos_x) * longint'(plate_res))
                    / (longint'(r.z_one) * full);
         end
      end else begin
         press = full + longint'(r.z_one) - longint'(r.z_two);
      end
      if (press > 65535) begin
         press = 65535;
      end
      p.point_valid = x_ok && y_ok;
      p.pressure    = p.point_valid ? press[rtpc_pkg::PRESS_W-1:0] : '0;
      return p;
   endfunction

   function void note_reading(touch_reading_type r);
      expected_points.push_back(predict_point(r));
   endfunction

   function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   function void check_result(touch_point_type got);
      touch_point_type want;
      if (expected_points.size() == 0) begin
         $display("%0t: result with nothing expected, got pos_x %0d pos_y %0d pressure %0d",
                  $time, got.pos_x, got.pos_y, got.pressure);
         error_count++;
         return;
      end
      want = expected_points.pop_front();
      points_checked++;
      compare_field("pos_x", want.pos_x, got.pos_x);
      compare_field("pos_y", want.pos_y, got.pos_y);
      compare_field("touch_pressure", want.pressure, got.pressure);
      compare_field("point_valid", want.point_valid, got.point_valid);
   endfunction

   function int pending();
      return expected_points.size();
   endfunction
endclass

module tb;
   import rtpc_pkg::*;

   // Waited out after the last result when emptying the pipeline; it is longer
   // than the path from an input transfer to the matching result, as a margin.
   localparam int LATENCY_CYCLES = 20;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SEGMENTS       = 6;
   localparam int SEGMENT_ITEMS  = 230;

   logic                    clock;
   logic                    reset        = 1'b1;
   logic                    req_valid    = 1'b0;
   logic                    req_stall;
   logic [SAMPLE_BITS-1:0]  req_x_first  = '0;
   logic [SAMPLE_BITS-1:0]  req_x_second = '0;
   logic [SAMPLE_BITS-1:0]  req_y_first  = '0;
   logic [SAMPLE_BITS-1:0]  req_y_second = '0;
   logic [SAMPLE_BITS-1:0]  req_z_one    = '0;
   logic [SAMPLE_BITS-1:0]  req_z_two    = '0;
   logic                    rsp_valid;
   logic                    rsp_stall    = 1'b0;
   logic [SAMPLE_BITS-1:0]  rsp_pos_x;
   logic [SAMPLE_BITS-1:0]  rsp_pos_y;
   logic [PRESS_W-1:0]      rsp_touch_pressure;
   logic                    rsp_point_valid;
   logic                    csr_valid    = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index    = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata    = '0;

   touch_scoreboard sb = new();

   // Percentages of cycles in which the sender and the receiver sit idle.
   int req_idle_pct   = 0;
   int rsp_stall_pct  = 0;
   // Long receiver hold-offs are requested by the stimulus and served by the
   // receiver process, each counter written by one process only.
   int hold_requests  = 0;
   int holds_served   = 0;
   int hold_left      = 0;
   int cycle_count    = 0;
   int readings_sent  = 0;
   int reg_writes     = 0;

   resistive_touch_point_compute_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_x_first        (req_x_first),
      .req_x_second       (req_x_second),
      .req_y_first        (req_y_first),
      .req_y_second       (req_y_second),
      .req_z_one          (req_z_one),
      .req_z_two          (req_z_two),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_touch_pressure (rsp_touch_pressure),
      .rsp_point_valid    (rsp_point_valid),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A watchdog on the cycle count, so that a hung handshake still ends the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, sb.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // The receiver. It stalls at random at the rate of the current phase and,
   // when a hold-off has been requested, stalls for a long stretch so that
   // the pipeline and its skid entry fill up and the input side is stalled.
   always @(posedge clock) begin
      if (holds_served < hold_requests) begin
         hold_left = HOLD_CYCLES;
         holds_served++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Monitor. Everything is sampled at the rising edge, before any of this
   // edge's nonblocking updates, so each transfer is seen exactly once.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.set_register(csr_index, csr_wdata);
         end
         if (req_valid && !req_stall) begin
            sb.note_reading('{x_first: req_x_first, x_second: req_x_second,
                              y_first: req_y_first, y_second: req_y_second,
                              z_one: req_z_one, z_two: req_z_two});
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result('{pos_x: rsp_pos_x, pos_y: rsp_pos_y,
                              pressure: rsp_touch_pressure,
                              point_valid: rsp_point_valid});
         end
      end
   end

   // Offers one reading set and returns at the edge where it is transferred.
   // The valid is left high, so a following call keeps it high without a gap.
   task automatic send_reading(touch_reading_type r);
      req_valid    <= 1'b1;
      req_x_first  <= r.x_first;
      req_x_second <= r.x_second;
      req_y_first  <= r.y_first;
      req_y_second <= r.y_second;
      req_z_one    <= r.z_one;
      req_z_two    <= r.z_two;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      readings_sent++;
   endtask

   task automatic idle_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stops offering and waits until every expected result has arrived, then
   // lets the pipeline latency pass so that the block is truly idle. The first
   // edge makes sure the monitor has noted the last transfer before counting.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
   endtask

   // One register write. The valid is dropped after the transfer before the task
   // returns, so that back-to-back writes never assign it twice in one time step.
   task automatic write_register(csr_reg_type idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      reg_writes++;
      @(posedge clock);
   endtask

   function automatic touch_reading_type make_reading(int xa, int xb, int ya, int yb,
                                                      int z1, int z2);
      touch_reading_type r;
      r.x_first  = xa[SAMPLE_BITS-1:0];
      r.x_second = xb[SAMPLE_BITS-1:0];
      r.y_first  = ya[SAMPLE_BITS-1:0];
      r.y_second = yb[SAMPLE_BITS-1:0];
      r.z_one    = z1[SAMPLE_BITS-1:0];
      r.z_two    = z2[SAMPLE_BITS-1:0];
      return r;
   endfunction

   // A converter sample, with the two rails turning up more often than chance.
   function automatic int rand_sample();
      int pick;
      pick = $urandom_range(15);
      if (pick == 0) begin
         return 0;
      end else if (pick == 1) begin
         return 4095;
      end
      return $urandom_range(4095);
   endfunction

   // A second sample within the noise window of the first, clamped to range.
   function automatic int near_sample(int a, int window);
      int offset;
      int v;
      offset = $urandom_range(window);
      v      = $urandom_range(1) ? a + offset : a - offset;
      if (v < 0) begin
         v = 0;
      end else if (v > 4095) begin
         v = 4095;
      end
      return v;
   endfunction

   // Most reading sets are clean touches, since only those reach the full
   // pressure arithmetic; the rest are noisy on one or both axes.
   function automatic touch_reading_type rand_reading(int window);
      int xa;
      int xb;
      int ya;
      int yb;
      int z1;
      int z2;
      xa = rand_sample();
      ya = rand_sample();
      xb = ($urandom_range(9) < 8) ? near_sample(xa, window) : rand_sample();
      yb = ($urandom_range(9) < 8) ? near_sample(ya, window) : rand_sample();
      z1 = rand_sample();
      z2 = rand_sample();
      case ($urandom_range(7))
         0: begin
            z1 = 0;
         end
         1: begin
            z2 = $urandom_range(z1);
         end
         2: begin
            z1 = $urandom_range(1, 8);
         end
         default: begin
         end
      endcase
      return make_reading(xa, xb, ya, yb, z1, z2);
   endfunction

   initial begin : stimulus
      int seg;
      int n;
      int plate;
      int window;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the reset settings: simple pressure formula and a
      // noise window of sixteen. Covers the rails, the window boundary on
      // each axis, odd sums in the average and both ends of the formula.
      send_reading(make_reading(0, 0, 0, 0, 0, 0));
      send_reading(make_reading(4095, 4095, 4095, 4095, 4095, 4095));
      send_reading(make_reading(100, 116, 200, 200, 1000, 2000));
      send_reading(make_reading(100, 117, 200, 200, 1000, 2000));
      send_reading(make_reading(1500, 1500, 3000, 2983, 300, 200));
      send_reading(make_reading(0, 4095, 4095, 0, 10, 20));
      send_reading(make_reading(5, 6, 7, 8, 4095, 0));
      send_reading(make_reading(2047, 2048, 1, 0, 0, 4095));
      settle();

      // Largest plate resistance and widest window: a Z1 of zero, Z2 not
      // above Z1, saturation of a large product and a normal quotient.
      write_register(REG_PLATE_RES, 16'd65535);
      write_register(REG_NOISE_WINDOW, 16'd4095);
      send_reading(make_reading(2000, 2001, 1000, 1000, 0, 500));
      send_reading(make_reading(2000, 2000, 1000, 1000, 800, 800));
      send_reading(make_reading(2000, 2000, 1000, 1000, 900, 100));
      send_reading(make_reading(0, 0, 4095, 4095, 1, 4095));
      send_reading(make_reading(3000, 3010, 500, 520, 2000, 3000));
      send_reading(make_reading(0, 4095, 4095, 0, 1234, 3456));
      settle();

      // Smallest non-zero plate and a zero window: only identical samples
      // pass, and a noisy point forces the pressure to zero.
      write_register(REG_PLATE_RES, 16'd1);
      write_register(REG_NOISE_WINDOW, 16'd0);
      send_reading(make_reading(1234, 1234, 55, 55, 100, 4000));
      send_reading(make_reading(1234, 1235, 55, 55, 0, 4000));
      send_reading(make_reading(1234, 1234, 10, 11, 100, 4000));
      send_reading(make_reading(0, 0, 0, 0, 4095, 4095));
      send_reading(make_reading(0, 0, 0, 0, 1, 4095));
      settle();

      // Random part in six segments, two per idling phase. Each segment
      // starts with the sender pausing until every result has come back,
      // then both registers are rewritten, extremes first.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: begin
               plate  = 0;
               window = 16;
            end
            1: begin
               plate  = 65535;
               window = 4095;
            end
            2: begin
               plate  = 1;
               window = 0;
            end
            3: begin
               plate  = $urandom_range(1, 65535);
               window = $urandom_range(4095);
            end
            4: begin
               plate  = $urandom_range(1, 4000);
               window = $urandom_range(64);
            end
            default: begin
               plate  = 0;
               window = $urandom_range(4095);
            end
         endcase
         settle();
         write_register(REG_PLATE_RES, plate[CSR_DATA_W-1:0]);
         write_register(REG_NOISE_WINDOW, window[CSR_DATA_W-1:0]);

         if (seg < 2) begin
            req_idle_pct  = 31;
            rsp_stall_pct = 52;
         end else if (seg < 4) begin
            req_idle_pct  = 52;
            rsp_stall_pct = 31;
         end else begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         // With neither side idling, a long receiver hold-off lets the
         // sender run the block full until its input is stalled.
         if (seg == 4) begin
            hold_requests++;
         end

         // Each cycle the sender idles with the phase's probability, so the
         // share of idle cycles matches the percentage.
         for (n = 0; n < SEGMENT_ITEMS; n++) begin
            while ($urandom_range(99) < req_idle_pct) begin
               idle_sender(1);
            end
            send_reading(rand_reading(window));
         end
      end

      settle();
      $display("Sent %0d reading sets and checked %0d touch points", readings_sent,
               sb.points_checked);
      $display("Made %0d register writes across plate and window extremes and idling phases",
               reg_writes);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/rtpc_pkg.sv
rtl/rtpc_front.sv
rtl/rtpc_div_step.sv
rtl/rtpc_skid.sv
rtl/resistive_touch_point_compute_top.sv
test/tb.sv
